>>> rtl/core/grain_keystream_byte_cipher_defines.svh
// Assertion macros used by the cipher checker.
`ifndef GRAIN_KEYSTREAM_BYTE_CIPHER_DEFINES_SVH
`define GRAIN_KEYSTREAM_BYTE_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define GKBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gkbc check failed: same-cycle implication");

// Next-cycle implication.
`define GKBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gkbc check failed: next-cycle implication");

`endif

>>> rtl/core/gkbc_pkg.sv
package gkbc_pkg;

	localparam int DEF_INIT_ROUNDS = 160;
	localparam int BYTE_ROUNDS     = 8;
	localparam int KEY_W           = 80;
	localparam int IV_W            = 64;
	localparam int STATE_W         = 80;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [1:0] CFG_IV       = 2'd2;

	// op codes carried in tuser
	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_DATA    = 1'b1;

	typedef enum logic [1:0] {
		OUT_RESTART,
		OUT_NOT_READY,
		OUT_DATA
	} out_kind_t;

	typedef struct packed {
		logic      load;       // load key / IV into the shift registers
		logic      capture;    // latch the incoming data byte
		logic      round;      // clock one cipher round
		logic      init_mode;  // feed z back during initialization
		logic      out_load;   // write the output register
		out_kind_t out_kind;   // what the output register receives
	} dp_cmd_t;

endpackage

>>> rtl/core/grain_keystream_byte_cipher.sv
// Grain v1 stream cipher, one byte per item. Write the 80-bit key (key_low,
// key_high) and the 64-bit IV over the cfg channel while the block is idle,
// then send a restart item (tuser = 0): the key goes into the NFSR, the IV
// into LFSR bits 0..63 with ones above, and INIT_ROUNDS initialization
// rounds run with the output bit fed back; its result is a zero byte.
// Each data item (tuser = 1) is XORed with the next eight keystream bits,
// first bit at the MSB, so the same call encrypts and decrypts. A data item
// sent before any restart returns zero with the not_ready flag (m_axis_tuser)
// set and leaves the cipher state alone. The datapath clocks one round per
// cycle. A data item is accepted, runs 8 rounds, then loads the output
// register when it is free; a restart runs INIT_ROUNDS rounds, a not-ready
// item none. One item is in progress at a time; the finished result sits
// in an output register, so the next item is accepted while the previous
// one waits to be taken. Register index 3 on the cfg channel is ignored.
module grain_keystream_byte_cipher #(
	parameter int INIT_ROUNDS = gkbc_pkg::DEF_INIT_ROUNDS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input item stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] op
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] result_byte
	output logic        m_axis_tuser    // [0] not_ready
);
	import gkbc_pkg::*;

	dp_cmd_t cmd;

	// registers are plain flops, always writable
	assign cfg_ready = 1'b1;

	gkbc_ctrl #(
		.INIT_ROUNDS(INIT_ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd)
	);

	gkbc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data_byte  (s_axis_tdata),
		.cmd        (cmd),
		.result_byte(m_axis_tdata),
		.not_ready  (m_axis_tuser)
	);

endmodule

>>> rtl/core/gkbc_datapath.sv
module gkbc_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic [7:0]       data_byte,
	input  gkbc_pkg::dp_cmd_t cmd,
	output logic [7:0]       result_byte,
	output logic             not_ready
);
	import gkbc_pkg::*;

	logic [63:0]        key_low_q;
	logic [15:0]        key_high_q;
	logic [IV_W-1:0]    iv_q;
	logic [STATE_W-1:0] lfsr_q;
	logic [STATE_W-1:0] nfsr_q;
	logic [7:0]         ks_q;
	logic [7:0]         data_q;
	logic [7:0]         result_q;
	logic               not_ready_q;

	logic x0, x1, x2, x3, x4, hv, z, fs, fb;
	logic [STATE_W-1:0] s, b;

	always_comb begin
		s  = lfsr_q;
		b  = nfsr_q;
		x0 = s[3];
		x1 = s[25];
		x2 = s[46];
		x3 = s[64];
		x4 = b[63];
		hv = x1 ^ x4 ^ (x0 & x3) ^ (x2 & x3) ^ (x3 & x4)
			^ (x0 & x1 & x2) ^ (x0 & x2 & x3) ^ (x0 & x2 & x4)
			^ (x1 & x2 & x4) ^ (x2 & x3 & x4);
		z  = hv ^ b[1] ^ b[2] ^ b[4] ^ b[10] ^ b[31] ^ b[43] ^ b[56];
		fs = s[0] ^ s[13] ^ s[23] ^ s[38] ^ s[51] ^ s[62];
		fb = s[0] ^ b[62] ^ b[60] ^ b[52] ^ b[45] ^ b[37] ^ b[33] ^ b[28]
			^ b[21] ^ b[14] ^ b[9] ^ b[0]
			^ (b[63] & b[60]) ^ (b[37] & b[33]) ^ (b[15] & b[9])
			^ (b[60] & b[52] & b[45]) ^ (b[33] & b[28] & b[21])
			^ (b[63] & b[45] & b[28] & b[9]) ^ (b[60] & b[52] & b[37] & b[33])
			^ (b[63] & b[60] & b[21] & b[15])
			^ (b[63] & b[60] & b[52] & b[45] & b[37])
			^ (b[33] & b[28] & b[21] & b[15] & b[9])
			^ (b[52] & b[45] & b[37] & b[33] & b[28] & b[21]);
		if (cmd.init_mode) begin
			fs = fs ^ z;
			fb = fb ^ z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_q       <= '0;
			lfsr_q     <= '0;
			nfsr_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW:  key_low_q  <= cfg_data;
					CFG_KEY_HIGH: key_high_q <= cfg_data[15:0];
					CFG_IV:       iv_q       <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				nfsr_q <= {key_high_q, key_low_q};
				lfsr_q <= {{(STATE_W-IV_W){1'b1}}, iv_q};
			end else if (cmd.round) begin
				lfsr_q <= {fs, lfsr_q[STATE_W-1:1]};
				nfsr_q <= {fb, nfsr_q[STATE_W-1:1]};
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture)
			data_q <= data_byte;
		if (cmd.round)
			ks_q <= {ks_q[6:0], z};
		if (cmd.out_load) begin
			case (cmd.out_kind)
				OUT_DATA: begin
					result_q    <= data_q ^ ks_q;
					not_ready_q <= 1'b0;
				end
				OUT_NOT_READY: begin
					result_q    <= '0;
					not_ready_q <= 1'b1;
				end
				default: begin
					result_q    <= '0;
					not_ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign result_byte = result_q;
	assign not_ready   = not_ready_q;

endmodule

>>> rtl/core/gkbc_ctrl.sv
module gkbc_ctrl #(
	parameter int INIT_ROUNDS = gkbc_pkg::DEF_INIT_ROUNDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output gkbc_pkg::dp_cmd_t cmd
);
	import gkbc_pkg::*;

	localparam int RW    = $clog2(INIT_ROUNDS);
	localparam int CNT_W = (RW > 3) ? RW : 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [CNT_W-1:0] cnt_q;
	logic            initialized_q;
	logic            out_valid_q;
	out_kind_t       kind_q;
	logic            accept;
	logic            out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept && (in_op == OP_RESTART);
		cmd.capture   = accept;
		cmd.round     = (state_q == ST_INIT) || (state_q == ST_RUN);
		cmd.init_mode = (state_q == ST_INIT);
		cmd.out_load  = (state_q == ST_DONE) && out_free;
		cmd.out_kind  = kind_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			initialized_q <= 1'b0;
			out_valid_q   <= 1'b0;
			kind_q        <= OUT_RESTART;
		end else begin
			// a new result replaces the one leaving this edge
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_op == OP_RESTART) begin
							kind_q  <= OUT_RESTART;
							cnt_q   <= CNT_W'(INIT_ROUNDS - 1);
							state_q <= ST_INIT;
						end else if (initialized_q) begin
							kind_q  <= OUT_DATA;
							cnt_q   <= CNT_W'(BYTE_ROUNDS - 1);
							state_q <= ST_RUN;
						end else begin
							kind_q  <= OUT_NOT_READY;
							state_q <= ST_DONE;
						end
					end
				end
				ST_INIT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						initialized_q <= 1'b1;
						state_q       <= ST_DONE;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/gkbc_checker.sv
`include "grain_keystream_byte_cipher_defines.svh"

module gkbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser
);

	// a stalled result holds
	`GKBC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// a not-ready result carries a zero byte
	`GKBC_ASSERT_NOW(a_not_ready_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'd0)

	// one item at a time: after an accept the input side closes
	`GKBC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a new result only appears after a busy cycle
	`GKBC_ASSERT_NOW(a_result_after_work, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind grain_keystream_byte_cipher gkbc_checker u_gkbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
